/* design/awad_pkg.sv */
// Shared constants and types for the windowed accelerometer average block.
`timescale 1ns / 1ps
`default_nettype none

package awad_pkg;

    // Fixed field widths.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned SENSOR_W   = 2;
    localparam int unsigned AXIS_W     = 12;
    localparam int unsigned THRESH_W   = 12;
    localparam int unsigned AXIS_COUNT = 3;

    localparam int unsigned AXIS_X = 0;
    localparam int unsigned AXIS_Y = 1;
    localparam int unsigned AXIS_Z = 2;

    // Build-time configuration.
    localparam int unsigned SENSOR_COUNT  = 4;
    localparam int unsigned WINDOW_LENGTH = 3;

    // Only sensor numbers that the two-bit field can carry get storage.
    localparam int unsigned SENSOR_SPAN = 1 << SENSOR_W;
    localparam int unsigned WIN_SENSORS =
        (SENSOR_COUNT < SENSOR_SPAN) ? SENSOR_COUNT : SENSOR_SPAN;
    localparam int unsigned SENS_IDX_W  =
        (WIN_SENSORS > 1) ? $clog2(WIN_SENSORS) : 1;
    localparam int unsigned SLOT_W      =
        (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    // Window sum, and the rounding numerator 2*|sum| + N.
    localparam int unsigned SUM_W = AXIS_W + $clog2(WINDOW_LENGTH);
    localparam int unsigned NUM_W = SUM_W + 1;

    // Exact floor division by 2*N via a rounded-up reciprocal.
    localparam int unsigned DIVISOR     = 2 * WINDOW_LENGTH;
    localparam int unsigned DIV_LOG     = $clog2(DIVISOR);
    localparam int unsigned RECIP_SHIFT = NUM_W + DIV_LOG;
    localparam int unsigned RECIP_W     = NUM_W + 2;
    localparam logic [63:0] RECIP_FULL  =
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int unsigned PROD_W      = NUM_W + RECIP_W;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef axis_t [AXIS_COUNT-1:0]   axis_vec_t;
    typedef sum_t  [AXIS_COUNT-1:0]   sum_vec_t;

    // Contents of the input register.
    typedef struct packed {
        logic                valid;
        logic [SENSOR_W-1:0] sensor_number;
        axis_vec_t           sample;
    } stage_t;

endpackage

`default_nettype wire

/* design/awad_if.sv */
// Handshake channel interfaces: sensor readings, window averages, threshold writes.
`timescale 1ns / 1ps
`default_nettype none

interface awad_reading_if;
    logic                              valid;
    logic                              ready;
    logic [awad_pkg::SENSOR_W-1:0]     sensor_number;
    logic [awad_pkg::BYTE_W-1:0]       x_upper_byte;
    logic [awad_pkg::BYTE_W-1:0]       x_lower_byte;
    logic [awad_pkg::BYTE_W-1:0]       y_upper_byte;
    logic [awad_pkg::BYTE_W-1:0]       y_lower_byte;
    logic [awad_pkg::BYTE_W-1:0]       z_upper_byte;
    logic [awad_pkg::BYTE_W-1:0]       z_lower_byte;

    modport source (
        output valid, sensor_number, x_upper_byte, x_lower_byte,
               y_upper_byte, y_lower_byte, z_upper_byte, z_lower_byte,
        input  ready
    );
    modport sink (
        input  valid, sensor_number, x_upper_byte, x_lower_byte,
               y_upper_byte, y_lower_byte, z_upper_byte, z_lower_byte,
        output ready
    );
endinterface

interface awad_average_if;
    logic                              valid;
    logic                              ready;
    logic [awad_pkg::SENSOR_W-1:0]     out_sensor_number;
    logic signed [awad_pkg::AXIS_W-1:0] x_average;
    logic signed [awad_pkg::AXIS_W-1:0] y_average;
    logic signed [awad_pkg::AXIS_W-1:0] z_average;

    modport source (
        output valid, out_sensor_number, x_average, y_average, z_average,
        input  ready
    );
    modport sink (
        input  valid, out_sensor_number, x_average, y_average, z_average,
        output ready
    );
endinterface

interface awad_threshold_if;
    logic                              valid;
    logic                              ready;
    logic [awad_pkg::THRESH_W-1:0]     dead_zone_threshold;

    modport source (
        output valid, dead_zone_threshold,
        input  ready
    );
    modport sink (
        input  valid, dead_zone_threshold,
        output ready
    );
endinterface

`default_nettype wire

/* design/awad_ingress.sv */
// Input register: takes a reading beat and assembles the three 12-bit axis samples.
`timescale 1ns / 1ps
`default_nettype none

module awad_ingress (
    input  logic             clk,
    input  logic             rst_n,
    awad_reading_if.sink     reading,
    input  logic             advance,
    output awad_pkg::stage_t stage
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [awad_pkg::SENSOR_W-1:0] sensor_reg;
    awad_pkg::axis_vec_t           sample_reg;
    awad_pkg::axis_vec_t           sample_next;
    logic                          load;

    assign reading.ready = !valid_reg || advance;
    assign load          = reading.valid && reading.ready;

    // Upper byte gives bits 11..4, the top nibble of the lower byte bits 3..0.
    always_comb
    begin
        sample_next[awad_pkg::AXIS_X] = {reading.x_upper_byte,
            reading.x_lower_byte[awad_pkg::BYTE_W-1 -: awad_pkg::NIBBLE_W]};
        sample_next[awad_pkg::AXIS_Y] = {reading.y_upper_byte,
            reading.y_lower_byte[awad_pkg::BYTE_W-1 -: awad_pkg::NIBBLE_W]};
        sample_next[awad_pkg::AXIS_Z] = {reading.z_upper_byte,
            reading.z_lower_byte[awad_pkg::BYTE_W-1 -: awad_pkg::NIBBLE_W]};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sensor_reg <= reading.sensor_number;
            sample_reg <= sample_next;
        end
    end

    assign stage.valid         = valid_reg;
    assign stage.sensor_number = sensor_reg;
    assign stage.sample        = sample_reg;

endmodule

`default_nettype wire

/* design/awad_window.sv */
// Per-sensor sample windows, write slots and running sums.
`timescale 1ns / 1ps
`default_nettype none

module awad_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update_en,
    input  logic [awad_pkg::SENSOR_W-1:0] sensor_number,
    input  awad_pkg::axis_vec_t           sample,
    output awad_pkg::sum_vec_t            sum_new,
    output logic                          in_range
);

    // One window word holds all three axes of a sample, since they are always
    // read and written together.
    awad_pkg::axis_vec_t win_reg [awad_pkg::WIN_SENSORS][awad_pkg::WINDOW_LENGTH];
    awad_pkg::sum_t  sum_reg [awad_pkg::WIN_SENSORS][awad_pkg::AXIS_COUNT];
    logic [awad_pkg::SLOT_W-1:0] slot_reg [awad_pkg::WIN_SENSORS];

    logic [awad_pkg::SENS_IDX_W-1:0] idx;
    logic [awad_pkg::SLOT_W-1:0]     slot;
    logic [awad_pkg::SLOT_W-1:0]     slot_next;
    awad_pkg::axis_t                 oldest [awad_pkg::AXIS_COUNT];

    assign in_range = 32'(sensor_number) < awad_pkg::SENSOR_COUNT;
    assign idx      = sensor_number[awad_pkg::SENS_IDX_W-1:0];
    assign slot     = slot_reg[idx];

    assign slot_next = (slot == awad_pkg::SLOT_W'(awad_pkg::WINDOW_LENGTH - 1))
                     ? '0 : slot + 1'b1;

    // The new sample replaces the oldest one, and the sum follows.
    always_comb
    begin
        for (int a = 0; a < awad_pkg::AXIS_COUNT; a++)
        begin
            oldest[a]  = win_reg[idx][slot][a];
            sum_new[a] = sum_reg[idx][a]
                       + awad_pkg::SUM_W'($signed(sample[a]))
                       - awad_pkg::SUM_W'(oldest[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < awad_pkg::WIN_SENSORS; s++)
            begin
                slot_reg[s] <= '0;
                for (int a = 0; a < awad_pkg::AXIS_COUNT; a++)
                begin
                    sum_reg[s][a] <= '0;
                end
                for (int w = 0; w < awad_pkg::WINDOW_LENGTH; w++)
                begin
                    win_reg[s][w] <= '0;
                end
            end
        end
        else if (update_en && in_range)
        begin
            slot_reg[idx]      <= slot_next;
            win_reg[idx][slot] <= sample;
            for (int a = 0; a < awad_pkg::AXIS_COUNT; a++)
            begin
                sum_reg[idx][a] <= sum_new[a];
            end
        end
    end

endmodule

`default_nettype wire

/* design/awad_dead_zone.sv */
// Threshold register, rounded window mean and dead-zone test for all three axes.
`timescale 1ns / 1ps
`default_nettype none

module awad_dead_zone (
    input  logic                clk,
    input  logic                rst_n,
    awad_threshold_if.sink      threshold,
    input  awad_pkg::sum_vec_t  sums,
    input  logic                in_range,
    output awad_pkg::axis_vec_t averages
);

    // Threshold is kept multiplied by the window length so it compares to the sum.
    logic [awad_pkg::SUM_W-1:0]  thr_scaled_reg;
    logic [awad_pkg::SUM_W-1:0]  thr_scaled_next;

    awad_pkg::sum_t              sum_val [awad_pkg::AXIS_COUNT];
    logic [awad_pkg::SUM_W-1:0]  mag     [awad_pkg::AXIS_COUNT];
    logic [awad_pkg::NUM_W-1:0]  num     [awad_pkg::AXIS_COUNT];
    logic [awad_pkg::PROD_W-1:0] prod    [awad_pkg::AXIS_COUNT];
    logic [awad_pkg::AXIS_W-1:0] quo     [awad_pkg::AXIS_COUNT];

    assign threshold.ready = 1'b1;
    assign thr_scaled_next = awad_pkg::SUM_W'(threshold.dead_zone_threshold)
                           * awad_pkg::SUM_W'(awad_pkg::WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_scaled_reg <= '0;
        end
        else if (threshold.valid)
        begin
            thr_scaled_reg <= thr_scaled_next;
        end
    end

    // Rounded magnitude is (2|sum| + N) / 2N, taken as a reciprocal product.
    always_comb
    begin
        for (int a = 0; a < awad_pkg::AXIS_COUNT; a++)
        begin
            sum_val[a] = sums[a];
            mag[a]     = sum_val[a][awad_pkg::SUM_W-1]
                       ? awad_pkg::SUM_W'(-sum_val[a]) : awad_pkg::SUM_W'(sum_val[a]);
            num[a]     = {mag[a], 1'b0} + awad_pkg::NUM_W'(awad_pkg::WINDOW_LENGTH);
            prod[a]    = awad_pkg::PROD_W'(num[a]) * awad_pkg::PROD_W'(awad_pkg::RECIP);
            quo[a]     = prod[a][awad_pkg::RECIP_SHIFT +: awad_pkg::AXIS_W];
            if (!in_range || (mag[a] < thr_scaled_reg))
            begin
                averages[a] = '0;
            end
            else if (sum_val[a][awad_pkg::SUM_W-1])
            begin
                averages[a] = -quo[a];
            end
            else
            begin
                averages[a] = quo[a];
            end
        end
    end

endmodule

`default_nettype wire

/* design/accel_window_average_deadzone.sv */
// Top level of the windowed accelerometer average with dead zone.
// Path: an accepted reading sits in the input register, then in the result register.
// The window update, mean and dead zone are combinational between the two registers.
// Throughput: one reading per cycle while the result register is not stalled.
// Reset: rst_n clears the windows, write slots, sums, threshold and all valid flags at once.
// The threshold port is always ready; a write takes effect at the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module accel_window_average_deadzone (
    input  logic            clk,
    input  logic            rst_n,
    awad_reading_if.sink    reading,
    awad_average_if.source  average,
    awad_threshold_if.sink  threshold
);

    // Stage one is the input register inside the ingress block. Stage two is the
    // result register below. Both move together whenever the result register is
    // empty or its beat is being taken, so a new reading is taken even while a
    // finished average waits downstream, as long as stage one is empty.
    awad_pkg::stage_t              stage;
    logic                          advance;
    awad_pkg::sum_vec_t            sum_new;
    logic                          in_range;
    awad_pkg::axis_vec_t           averages;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [awad_pkg::SENSOR_W-1:0] out_sensor_reg;
    awad_pkg::axis_vec_t           out_avg_reg;

    assign advance = !out_valid_reg || average.ready;

    awad_ingress u_ingress (
        .clk     (clk),
        .rst_n   (rst_n),
        .reading (reading),
        .advance (advance),
        .stage   (stage)
    );

    // The window state is written in the same cycle that the stage-one beat
    // moves on, so a reading of the same sensor right behind it sees the update.
    awad_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .update_en     (advance && stage.valid),
        .sensor_number (stage.sensor_number),
        .sample        (stage.sample),
        .sum_new       (sum_new),
        .in_range      (in_range)
    );

    // Out-of-range sensor numbers leave the state alone and report zeros.
    awad_dead_zone u_dead_zone (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold),
        .sums      (sum_new),
        .in_range  (in_range),
        .averages  (averages)
    );

    assign out_valid_next = advance ? stage.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.valid)
        begin
            out_sensor_reg <= stage.sensor_number;
            out_avg_reg    <= averages;
        end
    end

    assign average.valid             = out_valid_reg;
    assign average.out_sensor_number = out_sensor_reg;
    assign average.x_average         = out_avg_reg[awad_pkg::AXIS_X];
    assign average.y_average         = out_avg_reg[awad_pkg::AXIS_Y];
    assign average.z_average         = out_avg_reg[awad_pkg::AXIS_Z];

endmodule

`default_nettype wire

/* design/awad_checker.sv */
// Port-level checks for the windowed average block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module awad_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          reading_valid,
    input  logic                          reading_ready,
    input  logic                          average_valid,
    input  logic                          average_ready,
    input  logic [awad_pkg::SENSOR_W-1:0] out_sensor_number,
    input  logic [awad_pkg::AXIS_W-1:0]   x_average,
    input  logic [awad_pkg::AXIS_W-1:0]   y_average,
    input  logic [awad_pkg::AXIS_W-1:0]   z_average
);

    // A stalled average beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        average_valid && !average_ready |=>
            average_valid && $stable(out_sensor_number) && $stable(x_average)
            && $stable(y_average) && $stable(z_average))
    else $error("average beat changed while stalled");

    // An empty result register never holds back a new reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        !average_valid |-> reading_ready)
    else $error("reading not taken while the result register is empty");

    // A result that rises out of an empty register comes from an accepted reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(average_valid) |-> $past(reading_valid && reading_ready, 2))
    else $error("average beat appeared without a reading");

    // With the output side free, a reading moves through the input and result registers to the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (reading_valid && reading_ready && average_ready) ##1 average_ready
            |=> average_valid)
    else $error("reading did not produce an average in time");

endmodule

bind accel_window_average_deadzone awad_checker u_awad_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .reading_valid     (reading.valid),
    .reading_ready     (reading.ready),
    .average_valid     (average.valid),
    .average_ready     (average.ready),
    .out_sensor_number (average.out_sensor_number),
    .x_average         (average.x_average),
    .y_average         (average.y_average),
    .z_average         (average.z_average)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the windowed accelerometer average with dead zone.
`timescale 1ns / 1ps

module tb_top;
    import awad_pkg::*;

    // Give up after this many clock cycles.
    localparam int unsigned LIMIT_CYCLES = 500000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_READINGS = 100;
    localparam int AXIS_MAX = 2047;
    localparam int AXIS_MIN = -2048;
    localparam logic [THRESH_W-1:0] THRESH_OFF = '0;
    localparam logic [THRESH_W-1:0] THRESH_RANGE_TOP = 12'd2048;
    localparam logic [THRESH_W-1:0] THRESH_ALL_ONES = '1;

    // These are the kinds of axis value that the random part mixes.
    typedef enum int unsigned {
        STYLE_FULL,
        STYLE_NEAR,
        STYLE_EXTREME
    } value_style_e;

    // One sensor reading as it travels on the input channel.
    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_number;
        logic [BYTE_W-1:0]   x_upper_byte;
        logic [BYTE_W-1:0]   x_lower_byte;
        logic [BYTE_W-1:0]   y_upper_byte;
        logic [BYTE_W-1:0]   y_lower_byte;
        logic [BYTE_W-1:0]   z_upper_byte;
        logic [BYTE_W-1:0]   z_lower_byte;
    } reading_t;

    // One set of window averages as it leaves the block.
    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_number;
        axis_t               x_average;
        axis_t               y_average;
        axis_t               z_average;
    } average_t;

    logic clk = 1'b0;
    logic rst_n;

    awad_reading_if   reading_ch ();
    awad_average_if   average_ch ();
    awad_threshold_if threshold_ch ();

    accel_window_average_deadzone u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .reading   (reading_ch),
        .average   (average_ch),
        .threshold (threshold_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // This is the testbench's own copy of the block state. It is updated at the clock edge
    // where a reading beat or a threshold beat is accepted.
    axis_t               window_samples [SENSOR_COUNT][AXIS_COUNT][WINDOW_LENGTH];
    int unsigned         window_slot [SENSOR_COUNT];
    int                  window_total [SENSOR_COUNT][AXIS_COUNT];
    logic [THRESH_W-1:0] threshold_setting;

    // Averages that have been predicted and not yet seen, oldest first.
    average_t pending_averages [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          sender_burst = 1'b0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_prediction();
        for (int s = 0; s < SENSOR_COUNT; s++)
        begin
            window_slot[s] = 0;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                window_total[s][a] = 0;
                for (int k = 0; k < WINDOW_LENGTH; k++)
                    window_samples[s][a][k] = '0;
            end
        end
        threshold_setting = THRESH_OFF;
    endfunction

    // The upper byte gives axis bits 11..4 and the top nibble of the lower byte gives
    // bits 3..0. The low nibble of the lower byte is ignored.
    function automatic axis_t join_axis(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo);
        return axis_t'({hi, lo[BYTE_W-1 -: NIBBLE_W]});
    endfunction

    // The dead zone test compares |sum| with threshold * N, so that no fraction is
    // needed. A mean outside the dead zone is rounded half away from zero.
    function automatic axis_t rounded_mean(int total);
        int mag;
        int q;
        mag = (total < 0) ? -total : total;
        if (mag < int'(threshold_setting) * int'(WINDOW_LENGTH))
            return '0;
        q = (2 * mag + int'(WINDOW_LENGTH)) / (2 * int'(WINDOW_LENGTH));
        return axis_t'((total < 0) ? -q : q);
    endfunction

    function automatic average_t predict_average(reading_t r);
        average_t    result;
        axis_t       fresh [AXIS_COUNT];
        axis_t       means [AXIS_COUNT];
        int unsigned s;
        int unsigned slot;
        s = r.sensor_number;
        result = '0;
        result.sensor_number = r.sensor_number;
        // A sensor number without a window leaves the state alone and reports zeros.
        if (s >= SENSOR_COUNT)
            return result;
        fresh[AXIS_X] = join_axis(r.x_upper_byte, r.x_lower_byte);
        fresh[AXIS_Y] = join_axis(r.y_upper_byte, r.y_lower_byte);
        fresh[AXIS_Z] = join_axis(r.z_upper_byte, r.z_lower_byte);
        slot = (window_slot[s] < WINDOW_LENGTH) ? window_slot[s] : 0;
        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            // The oldest sample leaves the running sum and the new one takes its place.
            window_total[s][a] += int'(fresh[a]) - int'(window_samples[s][a][slot]);
            window_samples[s][a][slot] = fresh[a];
            means[a] = rounded_mean(window_total[s][a]);
        end
        window_slot[s] = (slot + 1 < WINDOW_LENGTH) ? slot + 1 : 0;
        result.x_average = means[AXIS_X];
        result.y_average = means[AXIS_Y];
        result.z_average = means[AXIS_Z];
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // This splits an axis value into its upper and lower register bytes. The ignored
    // low nibble is filled with noise.
    function automatic logic [2*BYTE_W-1:0] axis_bytes(axis_t v);
        return {v, NIBBLE_W'($urandom_range(0, 15))};
    endfunction

    function automatic reading_t make_reading(int unsigned s, int x, int y, int z);
        reading_t r;
        r.sensor_number = SENSOR_W'(s);
        {r.x_upper_byte, r.x_lower_byte} = axis_bytes(axis_t'(x));
        {r.y_upper_byte, r.y_lower_byte} = axis_bytes(axis_t'(y));
        {r.z_upper_byte, r.z_lower_byte} = axis_bytes(axis_t'(z));
        return r;
    endfunction

    function automatic int random_axis(value_style_e style, int spread);
        case (style)
            STYLE_NEAR:
                return int'($urandom_range(0, 2 * spread)) - spread;
            STYLE_EXTREME:
                case ($urandom_range(0, 4))
                    0: return AXIS_MAX;
                    1: return AXIS_MIN;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            default:
                return int'(axis_t'($urandom_range(0, 4095)));
        endcase
    endfunction

    // Most gaps between input beats are short. A few are long.
    function automatic int unsigned sender_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (sender_burst || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // This drives one reading beat. Valid stays high into the next beat when there is
    // no gap. The prediction is made at the edge where the beat is accepted, so the
    // expectation is queued before its averages can appear.
    task automatic send_reading(input reading_t r);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            reading_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        reading_ch.valid         <= 1'b1;
        reading_ch.sensor_number <= r.sensor_number;
        reading_ch.x_upper_byte  <= r.x_upper_byte;
        reading_ch.x_lower_byte  <= r.x_lower_byte;
        reading_ch.y_upper_byte  <= r.y_upper_byte;
        reading_ch.y_lower_byte  <= r.y_lower_byte;
        reading_ch.z_upper_byte  <= r.z_upper_byte;
        reading_ch.z_lower_byte  <= r.z_lower_byte;
        do
            @(posedge clk);
        while (!reading_ch.ready);
        pending_averages.push_back(predict_average(r));
    endtask

    task automatic send_xyz(input int unsigned s, input int x, input int y, input int z);
        send_reading(make_reading(s, x, y, z));
    endtask

    // This stops the input stream and waits until every predicted beat has come out.
    // A short pause then covers the pipeline before the threshold changes.
    task automatic drain_averages();
        @(negedge clk);
        reading_ch.valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        drain_averages();
        @(negedge clk);
        threshold_ch.valid               <= 1'b1;
        threshold_ch.dead_zone_threshold <= value;
        do
            @(posedge clk);
        while (!threshold_ch.ready);
        threshold_setting = value;
        @(negedge clk);
        threshold_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // These run at the reset threshold of zero. The windows start at zero, so the first
    // averages of each sensor are scaled down until the window has filled, and then
    // the window wraps around. The field extremes and minus one are covered, along
    // with lower bytes whose ignored nibble is set.
    task automatic test_window_fill();
        repeat (4) send_xyz(0, AXIS_MAX, AXIS_MIN, -1);
        send_reading('{sensor_number: 2'd1, x_upper_byte: 8'hFF, x_lower_byte: 8'hFF,
                       y_upper_byte: 8'h00, y_lower_byte: 8'h0F,
                       z_upper_byte: 8'h80, z_lower_byte: 8'h0F});
        send_xyz(2, 1, -1, 2);
        send_xyz(2, 1, -1, 0);
        send_xyz(3, 0, 0, 0);
    endtask

    // This test covers the dead zone at its top setting, where only the most negative
    // full window survives, and at all ones, where every average is zero. It also checks
    // the boundary where |sum| equals threshold * N exactly and one count below that.
    task automatic test_dead_zone();
        write_threshold(THRESH_RANGE_TOP);
        repeat (3) send_xyz(1, AXIS_MIN, AXIS_MIN, AXIS_MAX);
        send_xyz(0, AXIS_MAX, AXIS_MIN, AXIS_MIN);
        write_threshold(THRESH_ALL_ONES);
        send_xyz(1, AXIS_MIN, AXIS_MIN, AXIS_MIN);
        write_threshold(12'd100);
        repeat (3) send_xyz(3, 100, -100, 150);
        send_xyz(3, 99, -99, 50);
    endtask

    // Random readings are sent over several threshold settings. Near-zero values are
    // spread around the threshold so that sums land on both sides of the dead zone.
    // Runs on one sensor let its window fill with related values.
    task automatic test_random_stream();
        logic [THRESH_W-1:0] level;
        value_style_e        style;
        int unsigned         s;
        int                  spread;
        int unsigned         roll;
        s = 0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: level = THRESH_OFF;
                1: level = THRESH_RANGE_TOP;
                2: level = THRESH_ALL_ONES;
                3: level = 12'd1;
                default: level = THRESH_W'($urandom_range(0, 2048));
            endcase
            write_threshold(level);
            sender_burst = ($urandom_range(0, 3) == 0);
            spread = int'(level) + 64;
            if (spread > AXIS_MAX)
                spread = AXIS_MAX;
            for (int i = 0; i < PHASE_READINGS; i++)
            begin
                if ($urandom_range(0, 9) < 6)
                    s = $urandom_range(0, (1 << SENSOR_W) - 1);
                roll = $urandom_range(0, 9);
                style = (roll < 4) ? STYLE_NEAR : (roll < 8) ? STYLE_FULL : STYLE_EXTREME;
                send_xyz(s, random_axis(style, spread), random_axis(style, spread),
                         random_axis(style, spread));
            end
        end
        sender_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: backpressure and checking
    // ------------------------------------------------------------------

    // Ready drops for short stalls and sometimes for long ones. Long stretches with
    // ready held high occur between the stalls.
    initial
    begin : average_backpressure
        int unsigned stall;
        int unsigned hold;
        average_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 3)
                                                 : $urandom_range(8, 40);
            if (stall > 0)
            begin
                @(negedge clk);
                average_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            else
                @(negedge clk);
            average_ch.ready <= 1'b1;
            hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                                : $urandom_range(40, 150);
            repeat (hold) @(negedge clk);
        end
    end

    // Each accepted output beat is compared field by field with the oldest prediction.
    always @(posedge clk)
    begin : average_check
        average_t want;
        if (rst_n && average_ch.valid && average_ch.ready)
        begin
            if (pending_averages.size() == 0)
            begin
                $error("average beat for sensor %0d with no reading outstanding",
                       average_ch.out_sensor_number);
                mismatch_count++;
            end
            else
            begin
                want = pending_averages.pop_front();
                if (average_ch.out_sensor_number !== want.sensor_number)
                begin
                    $error("out_sensor_number: expected %0d, actual %0d",
                           want.sensor_number, average_ch.out_sensor_number);
                    mismatch_count++;
                end
                if (average_ch.x_average !== want.x_average)
                begin
                    $error("x_average: expected %0d, actual %0d",
                           want.x_average, average_ch.x_average);
                    mismatch_count++;
                end
                if (average_ch.y_average !== want.y_average)
                begin
                    $error("y_average: expected %0d, actual %0d",
                           want.y_average, average_ch.y_average);
                    mismatch_count++;
                end
                if (average_ch.z_average !== want.z_average)
                begin
                    $error("z_average: expected %0d, actual %0d",
                           want.z_average, average_ch.z_average);
                    mismatch_count++;
                end
            end
        end
    end

    // This watchdog catches a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("** accel_window_average_deadzone: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_prediction();
        rst_n                            = 1'b0;
        reading_ch.valid                 = 1'b0;
        reading_ch.sensor_number         = '0;
        reading_ch.x_upper_byte          = '0;
        reading_ch.x_lower_byte          = '0;
        reading_ch.y_upper_byte          = '0;
        reading_ch.y_lower_byte          = '0;
        reading_ch.z_upper_byte          = '0;
        reading_ch.z_lower_byte          = '0;
        threshold_ch.valid               = 1'b0;
        threshold_ch.dead_zone_threshold = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_window_fill();
        test_dead_zone();
        test_random_stream();

        // Let the last averages through, then keep watching for any stray beat.
        drain_averages();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_averages.size() == 0)
            $display("** accel_window_average_deadzone: PASSED **");
        else
            $display("** accel_window_average_deadzone: FAILED **");
        $finish;
    end

endmodule
